// ===== rtl/l3d_pkg.sv =====
package l3d_pkg;

  // Geometry of the torus and width of the per-cell age.
  localparam int SIDE     = 8;
  localparam int AGE_BITS = 16;

  localparam int CELLS   = SIDE * SIDE * SIDE;
  localparam int ROWS    = SIDE * SIDE;
  localparam int COORD_W = $clog2(SIDE);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int CELL_W  = $clog2(CELLS);
  localparam int POP_W   = $clog2(CELLS + 1);

  // Alive memory holds two banks of rows: current and next generation.
  localparam int ALIVE_AW      = ROW_W + 1;
  localparam int ALIVE_ENTRIES = 2 ** ALIVE_AW;

  // Fixed field widths of the ports.
  localparam int REQ_W     = 2;
  localparam int POS_W     = 3;
  localparam int AGE_OUT_W = 16;
  localparam int POP_OUT_W = 10;
  localparam int MASK_W    = 27;
  localparam int LIMIT_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int NBR_W     = 5;
  localparam int STAG_W    = 9;

  localparam logic [STAG_W-1:0] STAG_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [MASK_W-1:0]  SURVIVE_RST = MASK_W'(224);
  localparam logic [MASK_W-1:0]  BORN_RST    = MASK_W'(64);
  localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(60);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BORN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_STEP  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CELL,
    ST_STEP,
    ST_FIN,
    ST_RESP
  } st_e;

  typedef struct packed {
    logic              en;
    logic [CELL_W-1:0] idx;
  } clr_t;

  typedef struct packed {
    logic               rd;
    logic               wr;
    logic [ROW_W-1:0]   row;
    logic [COORD_W-1:0] x;
    logic               alive;
  } cell_cmd_t;

  // One finished row of the next generation, passed to the age unit.
  typedef struct packed {
    logic             vld;
    logic [ROW_W-1:0] row;
    logic [SIDE-1:0]  bits;
  } handoff_t;

  // Fold a port coordinate into 0..SIDE-1.
  function automatic logic [COORD_W-1:0] wrap_pos(input logic [POS_W-1:0] p);
    logic [4:0] v;
    v = 5'(p);
    for (int i = 0; i < 2; i++) begin
      if (v >= 5'(SIDE)) begin
        v = v - 5'(SIDE);
      end
    end
    return COORD_W'(v);
  endfunction

  // Neighbor coordinate: k = 0 is minus one, 1 is same, 2 is plus one.
  function automatic logic [COORD_W-1:0] nbr(input logic [COORD_W-1:0] c,
                                              input logic [1:0] k);
    logic [COORD_W-1:0] r;
    r = c;
    if (k == 2'd0) begin
      r = (c == '0) ? COORD_W'(SIDE - 1) : c - COORD_W'(1);
    end else if (k == 2'd2) begin
      r = (c == COORD_W'(SIDE - 1)) ? '0 : c + COORD_W'(1);
    end
    return r;
  endfunction

  function automatic logic [ROW_W-1:0] row_addr(input logic [COORD_W-1:0] z,
                                                 input logic [COORD_W-1:0] y);
    return ROW_W'(int'(z) * SIDE + int'(y));
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COORD_W-1:0] x);
    return CELL_W'(int'(row) * SIDE + int'(x));
  endfunction

  function automatic logic [COORD_W:0] popcnt(input logic [SIDE-1:0] bits);
    logic [COORD_W:0] n;
    n = '0;
    for (int i = 0; i < SIDE; i++) begin
      n = n + (COORD_W + 1)'(bits[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/l3d_req_if.sv =====
interface l3d_req_if;
  logic                       valid;
  logic                       ready;
  logic [l3d_pkg::REQ_W-1:0]  req_type;
  logic [l3d_pkg::POS_W-1:0]  pos_x;
  logic [l3d_pkg::POS_W-1:0]  pos_y;
  logic [l3d_pkg::POS_W-1:0]  pos_z;
  logic                       alive_in;

  modport source (output valid, req_type, pos_x, pos_y, pos_z, alive_in, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, pos_z, alive_in, output ready);
endinterface

// ===== rtl/l3d_rsp_if.sv =====
interface l3d_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          alive_out;
  logic [l3d_pkg::AGE_OUT_W-1:0] age_out;
  logic [l3d_pkg::POP_OUT_W-1:0] population;
  logic                          reseed_request;

  modport source (output valid, alive_out, age_out, population, reseed_request,
                  input ready);
  modport sink   (input valid, alive_out, age_out, population, reseed_request,
                  output ready);
endinterface

// ===== rtl/l3d_grid.sv =====
module l3d_grid (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  l3d_pkg::clr_t                 clr_i,
  input  logic                          step_start_i,
  input  logic                          swap_i,
  input  l3d_pkg::cell_cmd_t            cmd_i,
  input  logic [l3d_pkg::MASK_W-1:0]    survive_mask_i,
  input  logic [l3d_pkg::MASK_W-1:0]    born_mask_i,
  output l3d_pkg::handoff_t             ho_o,
  output logic                          busy_o,
  output logic                          rd_bit_o
);

  localparam int SIDE    = l3d_pkg::SIDE;
  localparam int COORD_W = l3d_pkg::COORD_W;
  localparam int ROW_W   = l3d_pkg::ROW_W;
  localparam int NBR_W   = l3d_pkg::NBR_W;
  localparam int AW      = l3d_pkg::ALIVE_AW;

  logic [SIDE-1:0] mem [l3d_pkg::ALIVE_ENTRIES];
  logic [SIDE-1:0] rdata_q;
  logic [AW-1:0]   raddr;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [SIDE-1:0] wdata;

  logic bank_q;

  // Row sweep: ry/rz select the row, ky/kz walk its nine neighbor rows.
  logic               iss_q;
  logic [COORD_W-1:0] ry_q, rz_q;
  logic [1:0]         ky_q, kz_q;

  logic             p_vld_q, p_center_q, p_last_q;
  logic [ROW_W-1:0] p_row_q;

  logic [NBR_W-1:0] acc_q [SIDE];
  logic [NBR_W-1:0] acc_d [SIDE];
  logic [NBR_W-1:0] tot   [SIDE];
  logic [SIDE-1:0]  center_q;
  logic [SIDE-1:0]  next_bits;

  l3d_pkg::handoff_t ho_q, ho_d;

  logic               c_wr_q;
  logic [ROW_W-1:0]   c_row_q;
  logic [COORD_W-1:0] c_x_q;
  logic               c_alive_q;
  logic [SIDE-1:0]    c_row_new;

  // Read address: neighbor rows while sweeping, else the addressed row.
  always_comb begin
    if (iss_q) begin
      raddr = {bank_q, l3d_pkg::row_addr(l3d_pkg::nbr(rz_q, kz_q),
                                         l3d_pkg::nbr(ry_q, ky_q))};
    end else begin
      raddr = {bank_q, cmd_i.row};
    end
  end

  // Add the three-wide window of each returned row into the lane counters.
  always_comb begin
    int li, ri;
    logic [NBR_W-1:0] contrib;
    li = 0;
    ri = 0;
    contrib = '0;
    for (int x = 0; x < SIDE; x++) begin
      li = (x == 0) ? SIDE - 1 : x - 1;
      ri = (x == SIDE - 1) ? 0 : x + 1;
      contrib = NBR_W'(rdata_q[li]) + NBR_W'(rdata_q[ri]);
      if (!p_center_q) begin
        contrib = contrib + NBR_W'(rdata_q[x]);
      end
      tot[x] = acc_q[x] + contrib;
      next_bits[x] = center_q[x] ? survive_mask_i[tot[x]] : born_mask_i[tot[x]];
      if (!p_vld_q) begin
        acc_d[x] = acc_q[x];
      end else if (p_last_q) begin
        acc_d[x] = '0;
      end else begin
        acc_d[x] = tot[x];
      end
    end
  end

  always_comb begin
    ho_d.vld  = p_vld_q && p_last_q;
    ho_d.row  = p_row_q;
    ho_d.bits = next_bits;
  end

  always_comb begin
    c_row_new = rdata_q;
    c_row_new[c_x_q] = c_alive_q;
  end

  // Write port: clearing pass, finished next-generation row, or cell seed.
  always_comb begin
    we    = 1'b0;
    waddr = {bank_q, c_row_q};
    wdata = c_row_new;
    if (clr_i.en && (int'(clr_i.idx) < l3d_pkg::ALIVE_ENTRIES)) begin
      we    = 1'b1;
      waddr = AW'(clr_i.idx);
      wdata = '0;
    end else if (ho_d.vld) begin
      we    = 1'b1;
      waddr = {~bank_q, p_row_q};
      wdata = next_bits;
    end else if (c_wr_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q      <= 1'b0;
      ry_q       <= '0;
      rz_q       <= '0;
      ky_q       <= '0;
      kz_q       <= '0;
      p_vld_q    <= 1'b0;
      p_center_q <= 1'b0;
      p_last_q   <= 1'b0;
      bank_q     <= 1'b0;
      ho_q       <= '0;
      c_wr_q     <= 1'b0;
      for (int x = 0; x < SIDE; x++) begin
        acc_q[x] <= '0;
      end
    end else begin
      if (step_start_i) begin
        iss_q <= 1'b1;
        ry_q  <= '0;
        rz_q  <= '0;
        ky_q  <= '0;
        kz_q  <= '0;
      end else if (iss_q) begin
        if (ky_q == 2'd2) begin
          ky_q <= '0;
          if (kz_q == 2'd2) begin
            kz_q <= '0;
            if (ry_q == COORD_W'(SIDE - 1)) begin
              ry_q <= '0;
              if (rz_q == COORD_W'(SIDE - 1)) begin
                iss_q <= 1'b0;
              end else begin
                rz_q <= rz_q + COORD_W'(1);
              end
            end else begin
              ry_q <= ry_q + COORD_W'(1);
            end
          end else begin
            kz_q <= kz_q + 2'd1;
          end
        end else begin
          ky_q <= ky_q + 2'd1;
        end
      end
      p_vld_q    <= iss_q;
      p_center_q <= iss_q && (ky_q == 2'd1) && (kz_q == 2'd1);
      p_last_q   <= iss_q && (ky_q == 2'd2) && (kz_q == 2'd2);
      if (swap_i) begin
        bank_q <= ~bank_q;
      end
      ho_q     <= ho_d;
      c_wr_q   <= cmd_i.wr;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_row_q <= l3d_pkg::row_addr(rz_q, ry_q);
    if (p_vld_q && p_center_q) begin
      center_q <= rdata_q;
    end
    if (cmd_i.rd || cmd_i.wr) begin
      c_row_q   <= cmd_i.row;
      c_x_q     <= cmd_i.x;
      c_alive_q <= cmd_i.alive;
    end
  end

  assign ho_o     = ho_q;
  assign busy_o   = iss_q | p_vld_q | ho_q.vld;
  assign rd_bit_o = rdata_q[c_x_q];

  // A seed write-back must never collide with a finished row write.
  a_no_wr_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(c_wr_q && p_vld_q && p_last_q))
    else $error("cell write overlaps next-generation row write");

endmodule

// ===== rtl/l3d_age.sv =====
module l3d_age (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  l3d_pkg::clr_t                   clr_i,
  input  l3d_pkg::handoff_t               ho_i,
  input  l3d_pkg::cell_cmd_t              cmd_i,
  output logic [l3d_pkg::AGE_BITS-1:0]    age_o,
  output logic                            busy_o
);

  localparam int SIDE     = l3d_pkg::SIDE;
  localparam int COORD_W  = l3d_pkg::COORD_W;
  localparam int ROW_W    = l3d_pkg::ROW_W;
  localparam int CELL_W   = l3d_pkg::CELL_W;
  localparam int AGE_BITS = l3d_pkg::AGE_BITS;

  logic [AGE_BITS-1:0] mem [l3d_pkg::CELLS];
  logic [AGE_BITS-1:0] rd_q;
  logic [CELL_W-1:0]   raddr;
  logic                we;
  logic [CELL_W-1:0]   waddr;
  logic [AGE_BITS-1:0] wdata;

  // Row walk: read each cell's age, then write it back, aged or zeroed, from the registered read.
  logic               act_q;
  logic [ROW_W-1:0]   arow_q;
  logic [SIDE-1:0]    abits_q;
  logic [COORD_W-1:0] ax_q;

  logic               wp_q;
  logic [CELL_W-1:0]  wa_q;
  logic               wl_q;

  logic [CELL_W-1:0]  cmd_addr;

  assign cmd_addr = l3d_pkg::cell_addr(cmd_i.row, cmd_i.x);
  assign raddr    = act_q ? l3d_pkg::cell_addr(arow_q, ax_q) : cmd_addr;

  always_comb begin
    we    = 1'b0;
    waddr = cmd_addr;
    wdata = AGE_BITS'(cmd_i.alive);
    if (clr_i.en) begin
      we    = 1'b1;
      waddr = clr_i.idx;
      wdata = '0;
    end else if (wp_q) begin
      we    = 1'b1;
      waddr = wa_q;
      wdata = wl_q ? rd_q + AGE_BITS'(1) : '0;
    end else if (cmd_i.wr) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      ax_q  <= '0;
      wp_q  <= 1'b0;
    end else begin
      if (ho_i.vld) begin
        act_q <= 1'b1;
        ax_q  <= '0;
      end else if (act_q) begin
        if (ax_q == COORD_W'(SIDE - 1)) begin
          act_q <= 1'b0;
        end
        ax_q <= ax_q + COORD_W'(1);
      end
      wp_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ho_i.vld) begin
      arow_q  <= ho_i.row;
      abits_q <= ho_i.bits;
    end
    wa_q <= l3d_pkg::cell_addr(arow_q, ax_q);
    wl_q <= abits_q[ax_q];
  end

  assign age_o  = rd_q;
  assign busy_o = act_q | wp_q;

  // The grid sweep paces rows so that a new one never lands mid-walk.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ho_i.vld |-> !act_q)
    else $error("row handed over while age walk still active");

endmodule

// ===== rtl/life3d_torus_automaton.sv =====
// Three-dimensional life on a torus with a 26-cell neighborhood. Each request
// is one of: write a cell (seeds alive and sets its age to 1 or 0), read a
// cell (returns alive bit and age), or step one generation (applies the
// survive and born masks to every cell, ages live cells, zeroes dead ones,
// counts the population and reports a reseed request on extinction or on a
// population that has stayed unchanged longer than the stagnation limit).
// Exactly one response comes back per request. After reset the block runs a
// clearing pass over every cell, one per cycle, before it takes the first
// request; configuration writes are taken during that pass. A cell read or
// write passes through the CELL and RESP states into the output register.
// A step reads the alive bits from a row-wide memory with one read port:
// every row of the next generation needs its nine neighbor rows read one per
// cycle, while the age memory is updated behind it one cell per cycle. The
// next request is taken as soon as a response is queued in the output
// register, even when the consumer has not taken it yet.
module life3d_torus_automaton (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  l3d_req_if.sink                       req_i,
  l3d_rsp_if.source                     rsp_o,
  input  logic                          cfg_we_i,
  input  logic [l3d_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [l3d_pkg::MASK_W-1:0]    cfg_wdata_i
);

  localparam int CELLS     = l3d_pkg::CELLS;
  localparam int CELL_W    = l3d_pkg::CELL_W;
  localparam int POP_W     = l3d_pkg::POP_W;
  localparam int STAG_W    = l3d_pkg::STAG_W;
  localparam int AGE_OUT_W = l3d_pkg::AGE_OUT_W;
  localparam int POP_OUT_W = l3d_pkg::POP_OUT_W;

  l3d_pkg::st_e state_q, state_d;

  // Configuration registers.
  logic [l3d_pkg::MASK_W-1:0]  survive_q, born_q;
  logic [l3d_pkg::LIMIT_W-1:0] limit_q;

  // Step bookkeeping.
  logic [CELL_W-1:0] clr_cnt_q;
  logic [POP_W-1:0]  pop_q;
  logic [POP_W-1:0]  last_pop_q;
  logic              last_vld_q;
  logic [STAG_W-1:0] stag_q;
  logic [STAG_W-1:0] stag_new;
  logic              same_pop;
  logic              reseed;

  // Current cell request and its pending response.
  logic                 is_wr_q;
  logic                 alive_q;
  logic                 res_alive_q;
  logic [AGE_OUT_W-1:0] res_age_q;
  logic [POP_OUT_W-1:0] res_pop_q;
  logic                 res_reseed_q;

  // Output register.
  logic                 out_vld_q;
  logic                 out_alive_q;
  logic [AGE_OUT_W-1:0] out_age_q;
  logic [POP_OUT_W-1:0] out_pop_q;
  logic                 out_reseed_q;
  logic                 out_free;

  logic req_fire;
  logic step_start;
  logic swap;
  logic grid_busy, age_busy, grid_bit;

  logic [l3d_pkg::AGE_BITS-1:0] age_rd;
  logic [31:0]                  age_ext;
  logic [31:0]                  pop_ext;
  logic [31:0]                  last_pop_ext;

  l3d_pkg::clr_t      clr;
  l3d_pkg::cell_cmd_t cmd;
  l3d_pkg::handoff_t  ho;

  l3d_grid u_grid (
    .clk_i,
    .rst_ni,
    .clr_i          (clr),
    .step_start_i   (step_start),
    .swap_i         (swap),
    .cmd_i          (cmd),
    .survive_mask_i (survive_q),
    .born_mask_i    (born_q),
    .ho_o           (ho),
    .busy_o         (grid_busy),
    .rd_bit_o       (grid_bit)
  );

  l3d_age u_age (
    .clk_i,
    .rst_ni,
    .clr_i  (clr),
    .ho_i   (ho),
    .cmd_i  (cmd),
    .age_o  (age_rd),
    .busy_o (age_busy)
  );

  assign req_fire = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;

  assign age_ext      = 32'(age_rd);
  assign pop_ext      = 32'(pop_q);
  assign last_pop_ext = 32'(last_pop_q);

  // Stagnation tracking for the step that is finishing.
  always_comb begin
    same_pop = last_vld_q && (pop_q == last_pop_q);
    if (!same_pop) begin
      stag_new = '0;
    end else if (stag_q == l3d_pkg::STAG_MAX) begin
      stag_new = stag_q;
    end else begin
      stag_new = stag_q + STAG_W'(1);
    end
    reseed = (pop_q == '0) || (stag_new > STAG_W'(limit_q));
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      l3d_pkg::ST_CLEAR: begin
        if (clr_cnt_q == CELL_W'(CELLS - 1)) begin
          state_d = l3d_pkg::ST_IDLE;
        end
      end
      l3d_pkg::ST_IDLE: begin
        if (req_fire) begin
          if (req_i.req_type == l3d_pkg::REQ_STEP) begin
            state_d = l3d_pkg::ST_STEP;
          end else begin
            state_d = l3d_pkg::ST_CELL;
          end
        end
      end
      l3d_pkg::ST_CELL: state_d = l3d_pkg::ST_RESP;
      l3d_pkg::ST_STEP: begin
        // Wait for the last row and its age write-back to drain.
        if (!grid_busy && !age_busy) begin
          state_d = l3d_pkg::ST_FIN;
        end
      end
      l3d_pkg::ST_FIN: state_d = l3d_pkg::ST_RESP;
      l3d_pkg::ST_RESP: begin
        if (out_free) begin
          state_d = l3d_pkg::ST_IDLE;
        end
      end
      default: state_d = l3d_pkg::ST_CLEAR;
    endcase
  end

  // Control outputs.
  always_comb begin
    req_i.ready = 1'b0;
    step_start  = 1'b0;
    swap        = 1'b0;
    clr.en      = 1'b0;
    clr.idx     = clr_cnt_q;
    cmd.rd      = 1'b0;
    cmd.wr      = 1'b0;
    cmd.row     = l3d_pkg::row_addr(l3d_pkg::wrap_pos(req_i.pos_z),
                                    l3d_pkg::wrap_pos(req_i.pos_y));
    cmd.x       = l3d_pkg::wrap_pos(req_i.pos_x);
    cmd.alive   = req_i.alive_in;
    case (state_q)
      l3d_pkg::ST_CLEAR: clr.en = 1'b1;
      l3d_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          if (req_i.req_type == l3d_pkg::REQ_STEP) begin
            step_start = 1'b1;
          end else begin
            // Code three acts as a read.
            cmd.rd = 1'b1;
            cmd.wr = (req_i.req_type == l3d_pkg::REQ_WRITE);
          end
        end
      end
      l3d_pkg::ST_FIN: swap = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= l3d_pkg::ST_CLEAR;
      clr_cnt_q  <= '0;
      survive_q  <= l3d_pkg::SURVIVE_RST;
      born_q     <= l3d_pkg::BORN_RST;
      limit_q    <= l3d_pkg::LIMIT_RST;
      pop_q      <= '0;
      last_pop_q <= '0;
      last_vld_q <= 1'b0;
      stag_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == l3d_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + CELL_W'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          l3d_pkg::CFG_SURVIVE: survive_q <= cfg_wdata_i;
          l3d_pkg::CFG_BORN:    born_q    <= cfg_wdata_i;
          l3d_pkg::CFG_LIMIT:   limit_q   <= cfg_wdata_i[l3d_pkg::LIMIT_W-1:0];
          default: begin
          end
        endcase
      end
      // Accumulate the live count row by row as the grid hands rows over.
      if (step_start) begin
        pop_q <= '0;
      end else if (ho.vld) begin
        pop_q <= pop_q + POP_W'(l3d_pkg::popcnt(ho.bits));
      end
      if (state_q == l3d_pkg::ST_FIN) begin
        last_pop_q <= pop_q;
        last_vld_q <= !reseed;
        stag_q     <= reseed ? '0 : stag_new;
      end
      if (state_q == l3d_pkg::ST_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      is_wr_q <= (req_i.req_type == l3d_pkg::REQ_WRITE);
      alive_q <= req_i.alive_in;
    end
    if (state_q == l3d_pkg::ST_CELL) begin
      res_alive_q  <= is_wr_q ? alive_q : grid_bit;
      res_age_q    <= is_wr_q ? AGE_OUT_W'(alive_q) : age_ext[AGE_OUT_W-1:0];
      res_pop_q    <= last_pop_ext[POP_OUT_W-1:0];
      res_reseed_q <= 1'b0;
    end else if (state_q == l3d_pkg::ST_FIN) begin
      res_alive_q  <= 1'b0;
      res_age_q    <= '0;
      res_pop_q    <= pop_ext[POP_OUT_W-1:0];
      res_reseed_q <= reseed;
    end
    if (state_q == l3d_pkg::ST_RESP && out_free) begin
      out_alive_q  <= res_alive_q;
      out_age_q    <= res_age_q;
      out_pop_q    <= res_pop_q;
      out_reseed_q <= res_reseed_q;
    end
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.alive_out      = out_alive_q;
  assign rsp_o.age_out        = out_age_q;
  assign rsp_o.population     = out_pop_q;
  assign rsp_o.reseed_request = out_reseed_q;

  // The running count can never exceed the number of cells.
  a_pop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_q <= POP_W'(CELLS))
    else $error("population count out of range");

  // A reseed clears the stagnation tracking.
  a_reseed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == l3d_pkg::ST_FIN && reseed) |=> (stag_q == '0 && !last_vld_q))
    else $error("reseed left stagnation tracking set");

endmodule

// ===== bench/tb_life3d_torus_automaton.sv =====
`timescale 1ns / 1ps

module tb_life3d_torus_automaton;

  localparam int SIDE      = l3d_pkg::SIDE;
  localparam int CELLS     = l3d_pkg::CELLS;
  localparam int REQ_W     = l3d_pkg::REQ_W;
  localparam int POS_W     = l3d_pkg::POS_W;
  localparam int MASK_W    = l3d_pkg::MASK_W;
  localparam int LIMIT_W   = l3d_pkg::LIMIT_W;
  localparam int AGE_BITS  = l3d_pkg::AGE_BITS;
  localparam int AGE_OUT_W = l3d_pkg::AGE_OUT_W;
  localparam int POP_OUT_W = l3d_pkg::POP_OUT_W;
  localparam int STAG_W    = l3d_pkg::STAG_W;
  localparam int CFG_IDX_W = l3d_pkg::CFG_IDX_W;

  // Request code three is not a named operation in the block; it reads a cell.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  // Totals for the run and the quiet-cycle watchdog.
  localparam int ITEMS_TOTAL = 1170;
  localparam int CALM_TAIL   = 150;
  localparam int QUIET_LIMIT = 5000;

  localparam logic [MASK_W-1:0] ALL_COUNTS = '1;
  localparam logic [MASK_W-1:0] NO_COUNTS  = '0;

  typedef struct packed {
    logic                 alive;
    logic [AGE_OUT_W-1:0] age;
    logic [POP_OUT_W-1:0] pop;
    logic                 reseed;
  } cell_reply_t;

  // Shadow copy of the torus. It advances on every accepted request and
  // holds the replies that the block still owes, oldest first.
  class torus_shadow;
    logic [MASK_W-1:0]   survive_bits;
    logic [MASK_W-1:0]   born_bits;
    logic [LIMIT_W-1:0]  stag_limit;
    logic                alive [CELLS];
    logic [AGE_BITS-1:0] age [CELLS];
    logic [POP_OUT_W-1:0] last_pop;
    logic                last_pop_ok;
    logic [STAG_W-1:0]   stag_count;
    cell_reply_t         owed_replies[$];
    int                  errors;

    function new();
      survive_bits = l3d_pkg::SURVIVE_RST;
      born_bits    = l3d_pkg::BORN_RST;
      stag_limit   = l3d_pkg::LIMIT_RST;
      for (int i = 0; i < CELLS; i++) begin
        alive[i] = 1'b0;
        age[i]   = '0;
      end
      last_pop    = '0;
      last_pop_ok = 1'b0;
      stag_count  = '0;
      errors      = 0;
    endfunction

    function int cell_slot(int x, int y, int z);
      return ((z % SIDE) * SIDE + (y % SIDE)) * SIDE + (x % SIDE);
    endfunction

    // Compute one generation over the whole torus; return the reseed flag.
    function logic advance_generation();
      logic grown [CELLS];
      int   live_count;
      int   n;
      int   i;
      logic live;
      logic reseed;
      live_count = 0;
      for (int z = 0; z < SIDE; z++) begin
        for (int y = 0; y < SIDE; y++) begin
          for (int x = 0; x < SIDE; x++) begin
            n = 0;
            for (int dz = -1; dz <= 1; dz++) begin
              for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                  if (dx != 0 || dy != 0 || dz != 0) begin
                    n += alive[cell_slot(x + dx + SIDE, y + dy + SIDE, z + dz + SIDE)];
                  end
                end
              end
            end
            i = cell_slot(x, y, z);
            live = alive[i] ? survive_bits[n] : born_bits[n];
            grown[i] = live;
            if (live) begin
              age[i] = age[i] + 1'b1;
              live_count++;
            end else begin
              age[i] = '0;
            end
          end
        end
      end
      alive = grown;

      if (last_pop_ok && live_count == int'(last_pop)) begin
        if (stag_count != l3d_pkg::STAG_MAX) begin
          stag_count = stag_count + 1'b1;
        end
      end else begin
        stag_count = '0;
      end
      last_pop    = POP_OUT_W'(live_count);
      last_pop_ok = 1'b1;

      reseed = (live_count == 0) || (stag_count > STAG_W'(stag_limit));
      if (reseed) begin
        last_pop_ok = 1'b0;
        stag_count  = '0;
      end
      return reseed;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] x,
                               logic [POS_W-1:0] y, logic [POS_W-1:0] z, logic a);
      cell_reply_t r;
      int          i;
      r = '0;
      i = cell_slot(x, y, z);
      if (kind == l3d_pkg::REQ_STEP) begin
        r.reseed = advance_generation();
      end else begin
        if (kind == l3d_pkg::REQ_WRITE) begin
          alive[i] = a;
          age[i]   = AGE_BITS'(a);
        end
        r.alive = alive[i];
        r.age   = AGE_OUT_W'(age[i]);
      end
      r.pop = last_pop;
      owed_replies.push_back(r);
    endfunction

    task flag_mismatch(string what, int want, int got);
      errors++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    task check_reply(cell_reply_t got);
      cell_reply_t want;
      if (owed_replies.size() == 0) begin
        flag_mismatch("reply with nothing outstanding", 0, 1);
      end else begin
        want = owed_replies.pop_front();
        if (got.alive !== want.alive) flag_mismatch("alive_out", want.alive, got.alive);
        if (got.age !== want.age) flag_mismatch("age_out", want.age, got.age);
        if (got.pop !== want.pop) flag_mismatch("population", want.pop, got.pop);
        if (got.reseed !== want.reseed) begin
          flag_mismatch("reseed_request", want.reseed, got.reseed);
        end
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [MASK_W-1:0]    cfg_wdata;

  l3d_req_if req_bus ();
  l3d_rsp_if rsp_bus ();

  torus_shadow shadow = new();

  int idle_pct;   // chance in percent of an idle burst, per request and per cycle
  int sent;
  int quiet;
  int box_x, box_y, box_z, box_ext;

  life3d_torus_automaton u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // Check every reply taken, and end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rsp_bus.valid && rsp_bus.ready) begin
      shadow.check_reply(cell_reply_t'{rsp_bus.alive_out, rsp_bus.age_out,
                                       rsp_bus.population, rsp_bus.reseed_request});
    end
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_life3d_torus_automaton: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stall the reply side in random bursts while idling is on.
  initial begin
    int stall;
    stall = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_bus.ready = 1'b0;
        stall--;
      end else begin
        rsp_bus.ready = 1'b1;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          stall = $urandom_range(1, 15);
        end
      end
    end
  end

  // Present one request, maybe after an idle burst, and hold it until taken.
  // Valid stays high on return so that the next request can follow back to back.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] x,
                              input logic [POS_W-1:0] y, input logic [POS_W-1:0] z,
                              input logic a);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 15);
    end
    @(negedge clk_i);
    if (gap != 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_bus.req_type = kind;
    req_bus.pos_x    = x;
    req_bus.pos_y    = y;
    req_bus.pos_z    = z;
    req_bus.alive_in = a;
    req_bus.valid    = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    shadow.note_request(kind, x, y, z, a);
    sent++;
  endtask

  // Drop valid and wait until every owed reply has come back.
  task automatic drain();
    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (shadow.owed_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
    case (idx)
      l3d_pkg::CFG_SURVIVE: shadow.survive_bits = value;
      l3d_pkg::CFG_BORN:    shadow.born_bits = value;
      l3d_pkg::CFG_LIMIT:   shadow.stag_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Reprogram the rule only once the block has nothing in flight.
  task automatic set_rules(input logic [MASK_W-1:0] survive, input logic [MASK_W-1:0] born,
                           input logic [LIMIT_W-1:0] limit);
    drain();
    write_reg(l3d_pkg::CFG_SURVIVE, survive);
    write_reg(l3d_pkg::CFG_BORN, born);
    write_reg(l3d_pkg::CFG_LIMIT, MASK_W'(limit));
  endtask

  function automatic logic [POS_W-1:0] near_box(int base);
    return POS_W'((base + $urandom_range(0, box_ext - 1)) % SIDE);
  endfunction

  // Seed a random box of the torus, possibly wrapping over an edge.
  task automatic seed_box(input int writes);
    int density;
    box_x   = $urandom_range(0, SIDE - 1);
    box_y   = $urandom_range(0, SIDE - 1);
    box_z   = $urandom_range(0, SIDE - 1);
    box_ext = $urandom_range(2, 5);
    density = $urandom_range(20, 80);
    repeat (writes) begin
      send_request(l3d_pkg::REQ_WRITE, near_box(box_x), near_box(box_y), near_box(box_z),
                   $urandom_range(0, 99) < density);
    end
  endtask

  task automatic random_request();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      send_request(l3d_pkg::REQ_STEP, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   1'($urandom));
    end else if (roll < 65) begin
      send_request(l3d_pkg::REQ_READ, near_box(box_x), near_box(box_y), near_box(box_z),
                   1'($urandom));
    end else if (roll < 85) begin
      send_request(l3d_pkg::REQ_WRITE, near_box(box_x), near_box(box_y), near_box(box_z),
                   1'($urandom));
    end else if (roll < 93) begin
      send_request(l3d_pkg::REQ_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   1'($urandom));
    end else begin
      send_request(REQ_SPARE, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                   1'($urandom));
    end
  endtask

  initial begin
    int phase;
    int len;
    logic [MASK_W-1:0]  survive;
    logic [MASK_W-1:0]  born;
    logic [LIMIT_W-1:0] limit;

    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = l3d_pkg::CFG_SURVIVE;
    cfg_wdata        = '0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = l3d_pkg::REQ_READ;
    req_bus.pos_x    = '0;
    req_bus.pos_y    = '0;
    req_bus.pos_z    = '0;
    req_bus.alive_in = 1'b0;
    idle_pct         = 0;
    sent             = 0;
    quiet            = 0;
    box_x            = 0;
    box_y            = 0;
    box_z            = 0;
    box_ext          = 2;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part under the reset rule. Step an empty torus first: extinction.
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);
    // Seed the corners, read two of them back; code three reads too.
    send_request(l3d_pkg::REQ_WRITE, 3'd0, 3'd0, 3'd0, 1'b1);
    send_request(l3d_pkg::REQ_WRITE, 3'd7, 3'd7, 3'd7, 1'b1);
    send_request(l3d_pkg::REQ_WRITE, 3'd7, 3'd0, 3'd7, 1'b0);
    send_request(l3d_pkg::REQ_WRITE, 3'd0, 3'd7, 3'd0, 1'b1);
    send_request(l3d_pkg::REQ_READ, 3'd7, 3'd7, 3'd7, 1'b0);
    send_request(REQ_SPARE, 3'd0, 3'd0, 3'd0, 1'b1);
    send_request(l3d_pkg::REQ_READ, 3'd3, 3'd4, 3'd5, 1'b1);
    // Give the cell at (2,2,2) six live neighbors so that it is born.
    for (int x = 1; x <= 3; x++) begin
      send_request(l3d_pkg::REQ_WRITE, POS_W'(x), 3'd1, 3'd1, 1'b1);
      send_request(l3d_pkg::REQ_WRITE, POS_W'(x), 3'd2, 3'd1, 1'b1);
    end
    send_request(l3d_pkg::REQ_STEP, 3'd7, 3'd7, 3'd7, 1'b1);
    send_request(l3d_pkg::REQ_READ, 3'd2, 3'd2, 3'd2, 1'b0);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);

    // Freeze the torus with a zero limit: the second equal count reseeds.
    set_rules(ALL_COUNTS, NO_COUNTS, 8'd0);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);
    send_request(l3d_pkg::REQ_READ, 3'd0, 3'd0, 3'd0, 1'b0);

    // Invert the torus: every dead cell is born and every live one dies.
    set_rules(NO_COUNTS, ALL_COUNTS, 8'd255);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);
    send_request(l3d_pkg::REQ_STEP, 3'd0, 3'd0, 3'd0, 1'b0);

    // Random phases: pick a rule, seed a box, then mix steps, reads and writes.
    phase = 0;
    while (sent < ITEMS_TOTAL) begin
      phase++;
      if (phase == 3) begin
        // Hold the population still long enough to pass the largest limit.
        idle_pct = 10;
        set_rules(ALL_COUNTS, NO_COUNTS, 8'd255);
        seed_box(12);
        repeat (260) begin
          send_request(l3d_pkg::REQ_STEP, POS_W'($urandom), POS_W'($urandom),
                       POS_W'($urandom), 1'($urandom));
          if ($urandom_range(0, 3) == 0) begin
            send_request(l3d_pkg::REQ_READ, near_box(box_x), near_box(box_y),
                         near_box(box_z), 1'($urandom));
          end
        end
      end else begin
        case ($urandom_range(0, 5))
          0: begin survive = l3d_pkg::SURVIVE_RST; born = l3d_pkg::BORN_RST; end
          1: begin survive = MASK_W'($urandom); born = MASK_W'($urandom); end
          2: begin survive = ALL_COUNTS; born = NO_COUNTS; end
          3: begin survive = NO_COUNTS; born = ALL_COUNTS; end
          4: begin
            survive = MASK_W'($urandom_range(0, 63)) << 3;
            born    = MASK_W'($urandom_range(0, 15)) << 4;
          end
          default: begin
            survive = MASK_W'($urandom & $urandom);
            born    = MASK_W'($urandom & $urandom & $urandom);
          end
        endcase
        case ($urandom_range(0, 3))
          0: limit = 8'd0;
          1: limit = 8'd255;
          2: limit = LIMIT_W'($urandom);
          default: limit = LIMIT_W'($urandom_range(1, 6));
        endcase
        // Run the tail of the stimulus with no idling on either side.
        if (sent >= ITEMS_TOTAL - CALM_TAIL) begin
          idle_pct = 0;
        end else begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 10;
            default: idle_pct = 30;
          endcase
        end
        set_rules(survive, born, limit);
        seed_box($urandom_range(6, 20));
        len = $urandom_range(20, 60);
        repeat (len) random_request();
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (shadow.errors == 0) begin
      $display("tb_life3d_torus_automaton: PASS");
    end else begin
      $display("tb_life3d_torus_automaton: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/l3d_pkg.sv
rtl/l3d_req_if.sv
rtl/l3d_rsp_if.sv
rtl/l3d_grid.sv
rtl/l3d_age.sv
rtl/life3d_torus_automaton.sv
bench/tb_life3d_torus_automaton.sv
